/* rtl/bsl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bsl_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam int MODE_W   = 4;
	localparam int POS_W    = 5;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 3;
	localparam int MATCH_W  = 5;
	localparam int COUNT_W  = 5;

	typedef enum logic [MODE_W-1:0] {
		MD_PUSH_BACK    = 4'd0,
		MD_PUSH_FRONT   = 4'd1,
		MD_INSERT       = 4'd2,
		MD_POP_BACK     = 4'd3,
		MD_POP_FRONT    = 4'd4,
		MD_ERASE        = 4'd5,
		MD_FIND         = 4'd6,
		MD_REMOVE_FIRST = 4'd7,
		MD_REMOVE_ALL   = 4'd8
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 3'd0,
		STS_FULL      = 3'd1,
		STS_EMPTY     = 3'd2,
		STS_BAD_POS   = 3'd3,
		STS_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_UP,
		S_WALK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                  we;
		logic [IDX_W-1:0]      waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  re;
		logic [IDX_W-1:0]      raddr;
	} mem_req_t;

	typedef struct packed {
		logic keep;
		logic take;
	} walk_dec_t;

	typedef struct packed {
		status_t              status;
		logic [MATCH_W-1:0]   match_index;
		logic [COUNT_W-1:0]   count_now;
		logic                 is_empty;
		logic                 is_full;
		logic [COUNT_W-1:0]   removed_count;
	} res_t;

endpackage

`default_nettype wire

/* rtl/bsl_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module bsl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/bsl_match.sv */
`timescale 1ns / 1ps
`default_nettype none

module bsl_match (
	input  wire logic [bsl_pkg::DATA_WIDTH-1:0] rdata,
	input  wire logic [bsl_pkg::DATA_WIDTH-1:0] val,
	input  wire bsl_pkg::mode_t                 mode,
	input  wire logic [bsl_pkg::IDX_W-1:0]      idx,
	input  wire logic [bsl_pkg::IDX_W-1:0]      start,
	input  wire logic                           hit,
	output bsl_pkg::walk_dec_t                  dec
);

	logic eq;
	logic first;

	assign eq    = (rdata == val);
	assign first = eq && !hit;

	always_comb begin
		dec = '0;
		unique case (mode)
			bsl_pkg::MD_REMOVE_ALL: begin
				dec.keep = !eq;
			end
			bsl_pkg::MD_REMOVE_FIRST: begin
				dec.keep = !first;
				dec.take = first;
			end
			bsl_pkg::MD_FIND: begin
				dec.take = first;
			end
			default: begin
				// pop front and erase drop the entry at the start index
				dec.keep = (idx != start);
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/bsl_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module bsl_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [bsl_pkg::MODE_W-1:0]     mode,
	input  wire logic [bsl_pkg::POS_W-1:0]      position,
	input  wire logic [bsl_pkg::VAL_W-1:0]      value,
	output bsl_pkg::mem_req_t                   mem_req,
	input  wire logic [bsl_pkg::DATA_WIDTH-1:0] rdata,
	input  wire logic                           slot_free,
	output logic                                done,
	output bsl_pkg::res_t                       res
);

	bsl_pkg::state_t state_q, state_d;
	bsl_pkg::mode_t  mode_q, mode_d;
	bsl_pkg::status_t st_q, st_d;

	logic [bsl_pkg::CNT_W-1:0]      cnt_q, cnt_d;
	logic [bsl_pkg::CNT_W-1:0]      rem_q, rem_d;
	logic [bsl_pkg::CNT_W-1:0]      j_q, j_d;
	logic [bsl_pkg::CNT_W-1:0]      rmv_q, rmv_d;
	logic [bsl_pkg::IDX_W-1:0]      rd_q, rd_d;
	logic [bsl_pkg::IDX_W-1:0]      start_q, start_d;
	logic [bsl_pkg::IDX_W-1:0]      match_q, match_d;
	logic [bsl_pkg::DATA_WIDTH-1:0] val_q, val_d;
	logic                           hit_q, hit_d;
	logic                           v_s1, v_d;
	logic [bsl_pkg::IDX_W-1:0]      idx_s1;

	logic               full;
	logic               empty;
	logic               finish;
	bsl_pkg::walk_dec_t dec;

	assign full   = (cnt_q == bsl_pkg::CNT_W'(bsl_pkg::DEPTH));
	assign empty  = (cnt_q == '0);
	assign finish = (rem_q == '0) && !v_s1;

	bsl_match u_match (
		.rdata (rdata),
		.val   (val_q),
		.mode  (mode_q),
		.idx   (idx_s1),
		.start (start_q),
		.hit   (hit_q),
		.dec   (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsl_pkg::S_IDLE;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			v_s1    <= v_d;
			hit_q   <= hit_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q  <= mode_d;
		st_q    <= st_d;
		rem_q   <= rem_d;
		j_q     <= j_d;
		rmv_q   <= rmv_d;
		rd_q    <= rd_d;
		start_q <= start_d;
		match_q <= match_d;
		val_q   <= val_d;
		idx_s1  <= rd_q;
	end

	always_comb begin
		state_d  = state_q;
		mode_d   = mode_q;
		st_d     = st_q;
		cnt_d    = cnt_q;
		rem_d    = rem_q;
		j_d      = j_q;
		rmv_d    = rmv_q;
		rd_d     = rd_q;
		start_d  = start_q;
		match_d  = match_q;
		val_d    = val_q;
		hit_d    = hit_q;
		v_d      = 1'b0;
		mem_req  = '0;
		in_ready = 1'b0;
		done     = 1'b0;

		unique case (state_q)
			bsl_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					mode_d  = bsl_pkg::mode_t'(mode);
					val_d   = value[bsl_pkg::DATA_WIDTH-1:0];
					st_d    = bsl_pkg::STS_OK;
					hit_d   = 1'b0;
					rmv_d   = '0;
					start_d = '0;
					j_d     = '0;
					rd_d    = '0;
					rem_d   = '0;
					state_d = bsl_pkg::S_DONE;
					case (mode) inside
						bsl_pkg::MD_PUSH_BACK: begin
							if (full) begin
								st_d = bsl_pkg::STS_FULL;
							end else begin
								start_d = cnt_q[bsl_pkg::IDX_W-1:0];
								state_d = bsl_pkg::S_UP;
							end
						end
						bsl_pkg::MD_PUSH_FRONT: begin
							if (full) begin
								st_d = bsl_pkg::STS_FULL;
							end else begin
								rem_d   = cnt_q;
								rd_d    = bsl_pkg::IDX_W'(cnt_q - 1'b1);
								state_d = bsl_pkg::S_UP;
							end
						end
						bsl_pkg::MD_INSERT: begin
							if (full) begin
								st_d = bsl_pkg::STS_FULL;
							end else if (position > bsl_pkg::POS_W'(cnt_q)) begin
								st_d = bsl_pkg::STS_BAD_POS;
							end else begin
								start_d = position[bsl_pkg::IDX_W-1:0];
								rem_d   = cnt_q - bsl_pkg::CNT_W'(position);
								rd_d    = bsl_pkg::IDX_W'(cnt_q - 1'b1);
								state_d = bsl_pkg::S_UP;
							end
						end
						bsl_pkg::MD_POP_BACK: begin
							if (empty) begin
								st_d = bsl_pkg::STS_EMPTY;
							end else begin
								cnt_d = cnt_q - 1'b1;
								rmv_d = bsl_pkg::CNT_W'(1);
							end
						end
						bsl_pkg::MD_ERASE: begin
							if (empty) begin
								st_d = bsl_pkg::STS_EMPTY;
							end else if (position >= bsl_pkg::POS_W'(cnt_q)) begin
								st_d = bsl_pkg::STS_BAD_POS;
							end else begin
								start_d = position[bsl_pkg::IDX_W-1:0];
								rd_d    = position[bsl_pkg::IDX_W-1:0];
								j_d     = bsl_pkg::CNT_W'(position);
								rem_d   = cnt_q - bsl_pkg::CNT_W'(position);
								state_d = bsl_pkg::S_WALK;
							end
						end
						bsl_pkg::MD_POP_FRONT, bsl_pkg::MD_REMOVE_FIRST,
						bsl_pkg::MD_REMOVE_ALL: begin
							if (empty) begin
								st_d = bsl_pkg::STS_EMPTY;
							end else begin
								rem_d   = cnt_q;
								state_d = bsl_pkg::S_WALK;
							end
						end
						bsl_pkg::MD_FIND: begin
							rem_d   = cnt_q;
							state_d = bsl_pkg::S_WALK;
						end
						default: begin
							state_d = bsl_pkg::S_DONE;
						end
					endcase
				end
			end

			bsl_pkg::S_UP: begin
				// shift entries up one place, top first
				if (rem_q != '0) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = rd_q;
					v_d           = 1'b1;
					rem_d         = rem_q - 1'b1;
					rd_d          = rd_q - 1'b1;
				end
				if (v_s1) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = idx_s1 + 1'b1;
					mem_req.wdata = rdata;
				end
				if (finish) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = start_q;
					mem_req.wdata = val_q;
					cnt_d         = cnt_q + 1'b1;
					state_d       = bsl_pkg::S_DONE;
				end
			end

			bsl_pkg::S_WALK: begin
				// scan upward; kept entries are written back at the compacted index
				if (rem_q != '0) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = rd_q;
					v_d           = 1'b1;
					rem_d         = rem_q - 1'b1;
					rd_d          = rd_q + 1'b1;
				end
				if (v_s1 && dec.keep) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = j_q[bsl_pkg::IDX_W-1:0];
					mem_req.wdata = rdata;
					j_d           = j_q + 1'b1;
				end
				if (v_s1 && dec.take) begin
					hit_d   = 1'b1;
					match_d = idx_s1;
				end
				if (finish) begin
					if (mode_q == bsl_pkg::MD_FIND) begin
						st_d = hit_q ? bsl_pkg::STS_OK : bsl_pkg::STS_NOT_FOUND;
					end else begin
						cnt_d = j_q;
						rmv_d = cnt_q - j_q;
						if (mode_q == bsl_pkg::MD_REMOVE_FIRST && !hit_q) begin
							st_d = bsl_pkg::STS_NOT_FOUND;
						end
					end
					state_d = bsl_pkg::S_DONE;
				end
			end

			bsl_pkg::S_DONE: begin
				if (slot_free) begin
					done    = 1'b1;
					state_d = bsl_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = bsl_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		res               = '0;
		res.status        = st_q;
		res.match_index   = hit_q ?
			{{(bsl_pkg::MATCH_W - bsl_pkg::IDX_W){1'b0}}, match_q} : '1;
		res.count_now     = bsl_pkg::COUNT_W'(cnt_q);
		res.is_empty      = (cnt_q == '0);
		res.is_full       = (cnt_q == bsl_pkg::CNT_W'(bsl_pkg::DEPTH));
		res.removed_count = bsl_pkg::COUNT_W'(rmv_q);
	end

endmodule

`default_nettype wire

/* rtl/bounded_sequential_list.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake              Fields
// in       in_valid / in_ready    mode, position, value
// out      out_valid / out_ready  status, match_index, count_now, is_empty, is_full,
//                                 removed_count
//
// A transaction moves or scans its entries (1 to 16, where there are any) one entry
// per cycle through the single list RAM port pair and the shared compare. A push, insert
// or find with nothing to move or scan, pop back, unknown modes and errors read no entry
// from the RAM. The next accept can come in the same cycle as the result becomes valid.
// in_ready is high only while the sequencer is idle.
// Reset clears the entry count; list storage needs no clearing.
// A stalled result holds in the output register; the next transaction may run
// meanwhile and waits at its end until the register is free.

module bounded_sequential_list (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [bsl_pkg::MODE_W-1:0]  mode,
	input  wire logic [bsl_pkg::POS_W-1:0]   position,
	input  wire logic [bsl_pkg::VAL_W-1:0]   value,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [bsl_pkg::STATUS_W-1:0]     status,
	output logic [bsl_pkg::MATCH_W-1:0]      match_index,
	output logic [bsl_pkg::COUNT_W-1:0]      count_now,
	output logic                             is_empty,
	output logic                             is_full,
	output logic [bsl_pkg::COUNT_W-1:0]      removed_count
);

	bsl_pkg::mem_req_t              mem_req;
	logic [bsl_pkg::DATA_WIDTH-1:0] rdata;
	logic                           slot_free;
	logic                           done;
	bsl_pkg::res_t                  res;
	bsl_pkg::res_t                  res_q;
	logic                           out_valid_q;

	assign slot_free = !out_valid_q || out_ready;

	bsl_ram #(
		.WIDTH (bsl_pkg::DATA_WIDTH),
		.DEPTH (bsl_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	bsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.position  (position),
		.value     (value),
		.mem_req   (mem_req),
		.rdata     (rdata),
		.slot_free (slot_free),
		.done      (done),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q.status;
	assign match_index   = res_q.match_index;
	assign count_now     = res_q.count_now;
	assign is_empty      = res_q.is_empty;
	assign is_full       = res_q.is_full;
	assign removed_count = res_q.removed_count;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count_now <= bsl_pkg::COUNT_W'(bsl_pkg::DEPTH)))
		else $error("count above depth");

	a_error_no_removal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != bsl_pkg::STS_OK) |-> (removed_count == '0))
		else $error("error status with entries removed");

	a_match_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && match_index != '1) |-> (status == bsl_pkg::STS_OK))
		else $error("match index reported without ok status");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready while a transaction is in progress");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_empty && is_full))
		else $error("empty and full together");
`endif

endmodule

`default_nettype wire
